[src/sorted_set_bank_engine_macros.svh]
// Assertion helpers used by the datapath.
`ifndef SORTED_SET_BANK_ENGINE_MACROS_SVH
`define SORTED_SET_BANK_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define SSE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted set bank check failed");

// Next-cycle implication.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted set bank check failed");

`endif

[src/sse_pkg.sv]
package sse_pkg;

  localparam int NumSetsDef     = 16;
  localparam int SetCapacityDef = 32;
  localparam int ValueWidthDef  = 32;
  localparam int MaxResults     = 32;

  localparam logic [3:0] MODE_INSERT  = 4'd0;
  localparam logic [3:0] MODE_DELETE  = 4'd1;
  localparam logic [3:0] MODE_MEMBER  = 4'd2;
  localparam logic [3:0] MODE_UNION   = 4'd3;
  localparam logic [3:0] MODE_INTER   = 4'd4;
  localparam logic [3:0] MODE_SIZE    = 4'd5;
  localparam logic [3:0] MODE_DIFF    = 4'd6;
  localparam logic [3:0] MODE_SYMDIFF = 4'd7;
  localparam logic [3:0] MODE_LIST    = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Merge keep mask: only in A, only in B, in both.
  localparam logic [2:0] KEEP_A    = 3'b001;
  localparam logic [2:0] KEEP_B    = 3'b010;
  localparam logic [2:0] KEEP_BOTH = 3'b100;

  typedef struct packed {
    logic [3:0]         mode;
    logic [3:0]         set_id;
    logic [3:0]         other_set_id;
    logic signed [31:0] value;
  } sse_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         count;
    logic               is_member;
    logic signed [31:0] element;
    logic               element_valid;
    logic               last;
  } sse_out_t;

  typedef struct packed {
    logic capture;
    logic merge_init;
    logic fetch;
    logic latch;
    logic step;
    logic copy_rd;
    logic copy_wr;
    logic commit_count;
    logic list_rd;
    logic list_emit;
    logic emit_single;
  } sse_cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       existed;
    logic       need_a;
    logic       need_b;
    logic       merge_done;
    logic       skip_wb;
    logic       copy_done;
    logic       list_done;
    logic       list_empty;
    logic       out_free;
  } sse_stat_t;

  function automatic logic is_single(input logic [3:0] m);
    return (m == MODE_INSERT) || (m == MODE_DELETE) || (m == MODE_MEMBER);
  endfunction

  function automatic logic is_pair(input logic [3:0] m);
    return (m == MODE_UNION) || (m == MODE_INTER) || (m == MODE_DIFF) ||
           (m == MODE_SYMDIFF);
  endfunction

endpackage

[src/sorted_set_bank_engine.sv]
// Sorted set bank engine: keeps NUM_SETS sets of up to SET_CAPACITY distinct signed values,
// each stored in ascending order in one element memory, and runs one command per
// input item (insert, delete, member, union, intersect, size, difference, symmetric
// difference, list). Insert, delete, member and the two-set commands are done as a sorted
// merge of the target set against either a second set or the item's value, written to a
// scratch buffer and copied back; a member query, and an insert that overflows, skip the
// copy. The one element memory read port is shared by both sides of a merge. One item is
// worked at a time; in_stall_o is high from acceptance until its last result is loaded into
// the output register, and the next item may be accepted while that result still waits.
// Unknown modes are dropped with no result. No clearing pass is needed after reset.
module sorted_set_bank_engine #(
  parameter int NUM_SETS     = sse_pkg::NumSetsDef,
  parameter int SET_CAPACITY = sse_pkg::SetCapacityDef,
  parameter int VALUE_WIDTH  = sse_pkg::ValueWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sse_pkg::sse_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sse_pkg::sse_out_t out_item_o
);

  sse_pkg::sse_cmd_t  cmd;
  sse_pkg::sse_stat_t stat;

  // Sequence each command.
  sse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the set bank, merge engine and output register.
  sse_dp #(
    .NUM_SETS     (NUM_SETS),
    .SET_CAPACITY (SET_CAPACITY),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[src/sse_ctrl.sv]
module sse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sse_pkg::sse_stat_t  stat_i,
  output sse_pkg::sse_cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_FETCH    = 4'd2;
  localparam logic [3:0] S_LATCH    = 4'd3;
  localparam logic [3:0] S_STEP     = 4'd4;
  localparam logic [3:0] S_COPY_RD  = 4'd5;
  localparam logic [3:0] S_COPY_WR  = 4'd6;
  localparam logic [3:0] S_EMIT     = 4'd7;
  localparam logic [3:0] S_LIST_RD  = 4'd8;
  localparam logic [3:0] S_LIST_OUT = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat_i.mode == sse_pkg::MODE_SIZE) begin
          state_d = S_EMIT;
        end else if (stat_i.mode == sse_pkg::MODE_LIST) begin
          state_d = stat_i.list_empty ? S_EMIT : S_LIST_RD;
        end else if (((stat_i.mode == sse_pkg::MODE_DELETE) ||
                      (stat_i.mode == sse_pkg::MODE_MEMBER)) && !stat_i.existed) begin
          state_d = S_EMIT;
        end else if (stat_i.mode < sse_pkg::MODE_LIST) begin
          cmd_o.merge_init = 1'b1;
          state_d          = S_FETCH;
        end else begin
          state_d = S_IDLE;  // drop unknown modes
        end
      end
      S_FETCH: begin
        if (stat_i.need_a || stat_i.need_b) begin
          cmd_o.fetch = 1'b1;
          state_d     = S_LATCH;
        end else begin
          state_d = S_STEP;
        end
      end
      S_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d     = (stat_i.need_a && stat_i.need_b) ? S_LATCH : S_STEP;
      end
      S_STEP: begin
        if (stat_i.merge_done) begin
          state_d = stat_i.skip_wb ? S_EMIT : S_COPY_RD;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_COPY_RD: begin
        if (stat_i.copy_done) begin
          cmd_o.commit_count = 1'b1;
          state_d            = S_EMIT;
        end else begin
          cmd_o.copy_rd = 1'b1;
          state_d       = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        state_d       = S_COPY_RD;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_LIST_RD: begin
        cmd_o.list_rd = 1'b1;
        state_d       = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.list_emit = 1'b1;
          state_d         = stat_i.list_done ? S_IDLE : S_LIST_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[src/sse_dp.sv]
`include "sorted_set_bank_engine_macros.svh"

module sse_dp #(
  parameter int NUM_SETS     = sse_pkg::NumSetsDef,
  parameter int SET_CAPACITY = sse_pkg::SetCapacityDef,
  parameter int VALUE_WIDTH  = sse_pkg::ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sse_pkg::sse_in_t   in_item_i,
  input  sse_pkg::sse_cmd_t  cmd_i,
  output sse_pkg::sse_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sse_pkg::sse_out_t  out_item_o
);

  localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int PW    = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CW    = $clog2(SET_CAPACITY + 1);
  localparam int DEPTH = NUM_SETS * SET_CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0]                    mode_q;
  logic [SW-1:0]                 s_q, o_q, s_in, o_in, cnt_idx;
  logic signed [VALUE_WIDTH-1:0] v_q, a_head_q, b_head_q, sel_v;
  logic signed [63:0]            vin64, elem64;
  logic                          existed_q, single_q, need_a_q, need_b_q, ovf_q;
  logic [2:0]                    keep_q, keep_d, cls;
  logic [CW-1:0]                 na_q, nb_q, i_q, j_q, n_q, k_q, cnt_rd, list_m;
  logic [CW-1:0]                 cnt_q [NUM_SETS];
  logic [NUM_SETS-1:0]           exists_q, exists_set;
  logic signed [VALUE_WIDTH-1:0] store [DEPTH];
  logic signed [VALUE_WIDTH-1:0] scratch [SET_CAPACITY];
  logic signed [VALUE_WIDTH-1:0] st_rdata_q, scr_rdata_q;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic                          a_ok, b_ok, a_lt, b_lt, take_a, take_b, both, kept, room;
  logic                          out_valid_q, out_free;
  sse_pkg::sse_out_t             out_q;

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [CW-1:0] p);
    return AW'(AW'(s) * AW'(SET_CAPACITY)) + AW'(p[PW-1:0]);
  endfunction

  // Reduce set indexes by the bank size.
  always_comb begin
    s_in = '0;
    o_in = '0;
    for (int k = 0; k < 16; k++) begin
      if (in_item_i.set_id == 4'(k)) s_in = SW'(k % NUM_SETS);
      if (in_item_i.other_set_id == 4'(k)) o_in = SW'(k % NUM_SETS);
    end
  end

  // Sets that the incoming item creates.
  always_comb begin
    exists_set = '0;
    if (in_item_i.mode <= sse_pkg::MODE_LIST) exists_set[s_in] = 1'b1;
    if (sse_pkg::is_pair(in_item_i.mode)) exists_set[o_in] = 1'b1;
  end

  assign vin64   = 64'(in_item_i.value);
  assign cnt_idx = cmd_i.capture ? s_in : (cmd_i.merge_init ? o_q : s_q);
  assign cnt_rd  = cnt_q[cnt_idx];

  always_comb begin
    unique case (mode_q)
      sse_pkg::MODE_INSERT, sse_pkg::MODE_UNION:
        keep_d = sse_pkg::KEEP_A | sse_pkg::KEEP_B | sse_pkg::KEEP_BOTH;
      sse_pkg::MODE_MEMBER, sse_pkg::MODE_INTER: keep_d = sse_pkg::KEEP_BOTH;
      sse_pkg::MODE_SYMDIFF: keep_d = sse_pkg::KEEP_A | sse_pkg::KEEP_B;
      default: keep_d = sse_pkg::KEEP_A;
    endcase
  end

  // Merge step compare.
  assign a_ok   = i_q < na_q;
  assign b_ok   = j_q < nb_q;
  assign a_lt   = a_head_q < b_head_q;
  assign b_lt   = b_head_q < a_head_q;
  assign take_a = a_ok && (!b_ok || a_lt);
  assign take_b = !take_a && b_ok && (!a_ok || b_lt);
  assign both   = a_ok && b_ok && !a_lt && !b_lt;
  assign cls    = {both, take_b, take_a};
  assign kept   = |(keep_q & cls);
  assign sel_v  = take_b ? b_head_q : a_head_q;
  assign room   = n_q < CW'(SET_CAPACITY);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_of(s_q, k_q);
    if (cmd_i.list_rd) begin
      rd_en = 1'b1;
    end else if (cmd_i.fetch) begin
      rd_en   = 1'b1;
      rd_addr = need_a_q ? addr_of(s_q, i_q) : addr_of(o_q, j_q);
    end else if (cmd_i.latch && need_a_q && need_b_q) begin
      rd_en   = 1'b1;
      rd_addr = addr_of(o_q, j_q);
    end
  end
  assign wr_addr = addr_of(s_q, k_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) store[wr_addr] <= scr_rdata_q;
    if (rd_en) st_rdata_q <= store[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && kept && room) scratch[n_q[PW-1:0]] <= sel_v;
    if (cmd_i.copy_rd) scr_rdata_q <= scratch[k_q[PW-1:0]];
  end

  // Item and merge registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q <= vin64[VALUE_WIDTH-1:0];
    end
    if (cmd_i.merge_init) begin
      single_q <= sse_pkg::is_single(mode_q);
      keep_q   <= keep_d;
      b_head_q <= v_q;
    end
    if (cmd_i.latch) begin
      if (need_a_q) a_head_q <= st_rdata_q;
      else b_head_q <= st_rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      s_q       <= '0;
      o_q       <= '0;
      existed_q <= 1'b0;
      na_q      <= '0;
      nb_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      n_q       <= '0;
      k_q       <= '0;
      need_a_q  <= 1'b0;
      need_b_q  <= 1'b0;
      ovf_q     <= 1'b0;
      exists_q  <= '0;
      for (int k = 0; k < NUM_SETS; k++) cnt_q[k] <= '0;
    end else begin
      if (cmd_i.capture) begin
        mode_q    <= in_item_i.mode;
        s_q       <= s_in;
        o_q       <= o_in;
        existed_q <= exists_q[s_in];
        na_q      <= cnt_rd;
        i_q       <= '0;
        j_q       <= '0;
        k_q       <= '0;
        ovf_q     <= 1'b0;
        exists_q  <= exists_q | exists_set;
      end
      if (cmd_i.merge_init) begin
        nb_q     <= sse_pkg::is_single(mode_q) ? CW'(1) : cnt_rd;
        n_q      <= '0;
        need_a_q <= (na_q != '0);
        need_b_q <= !sse_pkg::is_single(mode_q) && (cnt_rd != '0);
      end
      if (cmd_i.latch) begin
        if (need_a_q) need_a_q <= 1'b0;
        else need_b_q <= 1'b0;
      end
      if (cmd_i.step) begin
        if (kept) begin
          if (room) n_q <= CW'(n_q + CW'(1));
          else ovf_q <= 1'b1;
        end
        if (take_a || both) begin
          i_q      <= CW'(i_q + CW'(1));
          need_a_q <= CW'(i_q + CW'(1)) < na_q;
        end
        if (take_b || both) begin
          j_q      <= CW'(j_q + CW'(1));
          need_b_q <= !single_q && (CW'(j_q + CW'(1)) < nb_q);
        end
      end
      if (cmd_i.copy_wr || cmd_i.list_emit) k_q <= CW'(k_q + CW'(1));
      if (cmd_i.commit_count) cnt_q[s_q] <= n_q;
    end
  end

  // List length is capped at the result limit.
  assign list_m = (32'(na_q) > 32'(sse_pkg::MaxResults)) ? CW'(sse_pkg::MaxResults) : na_q;
  assign elem64 = 64'(st_rdata_q);

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_single || cmd_i.list_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      if (((mode_q == sse_pkg::MODE_DELETE) || (mode_q == sse_pkg::MODE_MEMBER)) &&
          !existed_q) begin
        out_q.status <= sse_pkg::ST_MISSING;
      end else if (ovf_q && ((mode_q == sse_pkg::MODE_INSERT) ||
                             (mode_q == sse_pkg::MODE_UNION) ||
                             (mode_q == sse_pkg::MODE_SYMDIFF))) begin
        out_q.status <= sse_pkg::ST_OVERFLOW;
      end else begin
        out_q.status <= sse_pkg::ST_OK;
      end
      out_q.count         <= 6'(cnt_rd);
      out_q.is_member     <= (mode_q == sse_pkg::MODE_MEMBER) && existed_q && (n_q != '0);
      out_q.element       <= '0;
      out_q.element_valid <= 1'b0;
      out_q.last          <= 1'b1;
    end else if (cmd_i.list_emit) begin
      out_q.status        <= sse_pkg::ST_OK;
      out_q.count         <= 6'(na_q);
      out_q.is_member     <= 1'b0;
      out_q.element       <= elem64[31:0];
      out_q.element_valid <= 1'b1;
      out_q.last          <= stat_o.list_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign stat_o.mode       = mode_q;
  assign stat_o.existed    = existed_q;
  assign stat_o.need_a     = need_a_q;
  assign stat_o.need_b     = need_b_q;
  assign stat_o.merge_done = !a_ok && !b_ok;
  assign stat_o.skip_wb    = (mode_q == sse_pkg::MODE_MEMBER) ||
                             ((mode_q == sse_pkg::MODE_INSERT) && ovf_q);
  assign stat_o.copy_done  = k_q >= n_q;
  assign stat_o.list_done  = (CW'(k_q + CW'(1)) >= list_m);
  assign stat_o.list_empty = (na_q == '0);
  assign stat_o.out_free   = out_free;

  `SSE_ASSERT(a_fill_cap, 1'b1, n_q <= CW'(SET_CAPACITY))
  `SSE_ASSERT(a_idx_bound, 1'b1, (i_q <= na_q) && (j_q <= nb_q))
  `SSE_ASSERT_NEXT(a_list_item, cmd_i.list_emit, out_q.element_valid && !out_q.is_member)

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 16;
  localparam int CAP   = 32;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  sse_pkg::sse_in_t  in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  sse_pkg::sse_out_t out_item_o;

  sorted_set_bank_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the set bank, updated as each item is accepted.
  logic signed [31:0] bank_vals [NSETS][CAP];
  int                 bank_cnt [NSETS];
  bit                 bank_live [NSETS];

  sse_pkg::sse_in_t  cmd_queue [$];
  sse_pkg::sse_out_t expected_results [$];
  int       in_idle_pct = 24, out_idle_pct = 86;
  bit       hold_in = 1'b0;
  int       mismatches = 0, results_seen = 0, cmds_sent = 0, lists_seen = 0;
  int       ovf_seen = 0;

  function automatic void queue_cmd(sse_pkg::sse_in_t c);
    cmd_queue.insert(cmd_queue.size(), c);
  endfunction

  function automatic void expect_result(sse_pkg::sse_out_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic sse_pkg::sse_out_t mk_result(logic [1:0] st, int cnt, bit mem,
                                                  logic signed [31:0] el, bit ev, bit lst);
    sse_pkg::sse_out_t r;
    r.status = st; r.count = cnt[5:0]; r.is_member = mem;
    r.element = el; r.element_valid = ev; r.last = lst;
    return r;
  endfunction

  // Merge two shadow sets; keep selects only-in-a, only-in-b, in-both.
  // Returns 1 when the result was truncated.
  function automatic bit merge_into(int a, int b, logic [2:0] keep);
    logic signed [31:0] buf_v [CAP];
    logic signed [31:0] v;
    logic [2:0] cls;
    int i = 0, j = 0, n = 0;
    bit ovf = 0;
    while (i < bank_cnt[a] || j < bank_cnt[b]) begin
      if (j >= bank_cnt[b] || (i < bank_cnt[a] && bank_vals[a][i] < bank_vals[b][j])) begin
        v = bank_vals[a][i]; i++; cls = sse_pkg::KEEP_A;
      end else if (i >= bank_cnt[a] || bank_vals[b][j] < bank_vals[a][i]) begin
        v = bank_vals[b][j]; j++; cls = sse_pkg::KEEP_B;
      end else begin
        v = bank_vals[a][i]; i++; j++; cls = sse_pkg::KEEP_BOTH;
      end
      if ((keep & cls) != 0) begin
        if (n < CAP) begin
          buf_v[n] = v; n++;
        end else begin
          ovf = 1;
        end
      end
    end
    for (int k = 0; k < n; k++) bank_vals[a][k] = buf_v[k];
    bank_cnt[a] = n;
    return ovf;
  endfunction

  // Apply one command to the shadow bank and queue what it should produce.
  task automatic predict_command(sse_pkg::sse_in_t c);
    int s, o, n, pos;
    bit existed, mem;
    logic [1:0] st;
    logic signed [31:0] v;
    s = c.set_id; o = c.other_set_id; v = c.value;
    st = sse_pkg::ST_OK; mem = 0;
    if (c.mode > sse_pkg::MODE_LIST) return;  // unknown mode: drop silently
    existed = bank_live[s];
    bank_live[s] = 1;
    n = bank_cnt[s];
    case (c.mode)
      sse_pkg::MODE_INSERT: begin
        pos = 0;
        while (pos < n && bank_vals[s][pos] < v) pos++;
        if (!(pos < n && bank_vals[s][pos] == v)) begin
          if (n >= CAP) begin
            st = sse_pkg::ST_OVERFLOW;
          end else begin
            for (int k = n; k > pos; k--) bank_vals[s][k] = bank_vals[s][k-1];
            bank_vals[s][pos] = v;
            bank_cnt[s] = n + 1;
          end
        end
      end
      sse_pkg::MODE_DELETE: begin
        if (!existed) begin
          st = sse_pkg::ST_MISSING;
        end else begin
          for (int k = 0; k < n; k++) begin
            if (bank_vals[s][k] == v) begin
              for (int m = k; m < n - 1; m++) bank_vals[s][m] = bank_vals[s][m+1];
              bank_cnt[s] = n - 1;
              break;
            end
          end
        end
      end
      sse_pkg::MODE_MEMBER: begin
        if (!existed) begin
          st = sse_pkg::ST_MISSING;
        end else begin
          for (int k = 0; k < n; k++) if (bank_vals[s][k] == v) mem = 1;
        end
      end
      sse_pkg::MODE_UNION: begin
        bank_live[o] = 1;
        if (merge_into(s, o, sse_pkg::KEEP_A | sse_pkg::KEEP_B | sse_pkg::KEEP_BOTH))
          st = sse_pkg::ST_OVERFLOW;
      end
      sse_pkg::MODE_INTER: begin
        bank_live[o] = 1;
        void'(merge_into(s, o, sse_pkg::KEEP_BOTH));
      end
      sse_pkg::MODE_DIFF: begin
        bank_live[o] = 1;
        void'(merge_into(s, o, sse_pkg::KEEP_A));
      end
      sse_pkg::MODE_SYMDIFF: begin
        bank_live[o] = 1;
        if (merge_into(s, o, sse_pkg::KEEP_A | sse_pkg::KEEP_B)) st = sse_pkg::ST_OVERFLOW;
      end
      sse_pkg::MODE_LIST: begin
        lists_seen++;
        if (n == 0) begin
          expect_result(mk_result(sse_pkg::ST_OK, 0, 0, '0, 0, 1));
        end else begin
          for (int k = 0; k < n && k < sse_pkg::MaxResults; k++)
            expect_result(mk_result(sse_pkg::ST_OK, n, 0, bank_vals[s][k], 1,
                                    (k + 1 == n) || (k + 1 == sse_pkg::MaxResults)));
        end
        return;
      end
      default: ;
    endcase
    if (st == sse_pkg::ST_OVERFLOW) ovf_seen++;
    expect_result(mk_result(st, bank_cnt[s], mem, '0, 0, 1));
  endtask

  function automatic sse_pkg::sse_in_t mk_cmd(logic [3:0] m, int s, int o, logic [31:0] v);
    sse_pkg::sse_in_t c;
    c.mode = m; c.set_id = s[3:0]; c.other_set_id = o[3:0]; c.value = v;
    return c;
  endfunction

  // Drive: advance to the next item on acceptance, idle at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_o)) begin
        if (in_valid_i) begin
          predict_command(in_item_i);
          cmds_sent++;
        end
        if (cmd_queue.size() > 0 && !hold_in && $urandom_range(99) >= in_idle_pct) begin
          in_item_i  <= cmd_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        sse_pkg::sse_out_t e;
        e = expected_results.pop_front();
        if (out_item_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_item_o);
        end
      end
    end
  end

  task automatic drain_all();
    while (cmd_queue.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(40) - 20;  // small pool so hits repeat
    endcase
  endfunction

  // Random item mix: mostly useful commands, a few unknown modes.
  function automatic sse_pkg::sse_in_t rand_cmd();
    int pick, s, o;
    s = $urandom_range(5) == 0 ? $urandom_range(15) : $urandom_range(3);
    o = $urandom_range(4) == 0 ? $urandom_range(15) : $urandom_range(3);
    pick = $urandom_range(99);
    if (pick < 40) return mk_cmd(sse_pkg::MODE_INSERT, s, o, rand_value());
    if (pick < 50) return mk_cmd(sse_pkg::MODE_DELETE, s, o, rand_value());
    if (pick < 58) return mk_cmd(sse_pkg::MODE_MEMBER, s, o, rand_value());
    if (pick < 64) return mk_cmd(sse_pkg::MODE_UNION, s, o, $urandom);
    if (pick < 68) return mk_cmd(sse_pkg::MODE_INTER, s, o, $urandom);
    if (pick < 72) return mk_cmd(sse_pkg::MODE_DIFF, s, o, $urandom);
    if (pick < 77) return mk_cmd(sse_pkg::MODE_SYMDIFF, s, o, $urandom);
    if (pick < 82) return mk_cmd(sse_pkg::MODE_SIZE, s, o, $urandom);
    if (pick < 94) return mk_cmd(sse_pkg::MODE_LIST, s, o, $urandom);
    return mk_cmd(4'($urandom_range(15, 9)), s, o, $urandom);
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: missing sets, extremes, duplicates, every mode, same set twice.
    queue_cmd(mk_cmd(sse_pkg::MODE_DELETE, 9, 0, 5));
    queue_cmd(mk_cmd(sse_pkg::MODE_MEMBER, 10, 0, 5));
    queue_cmd(mk_cmd(sse_pkg::MODE_LIST, 11, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_SIZE, 12, 0, 0));
    queue_cmd(mk_cmd(4'd15, 13, 14, 32'hffff_ffff));
    queue_cmd(mk_cmd(sse_pkg::MODE_MEMBER, 13, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_INSERT, 15, 0, 32'h8000_0000));
    queue_cmd(mk_cmd(sse_pkg::MODE_INSERT, 15, 0, 32'h7fff_ffff));
    queue_cmd(mk_cmd(sse_pkg::MODE_INSERT, 15, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_INSERT, 15, 0, 32'hffff_ffff));
    queue_cmd(mk_cmd(sse_pkg::MODE_INSERT, 15, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_MEMBER, 15, 0, 32'h7fff_ffff));
    queue_cmd(mk_cmd(sse_pkg::MODE_DELETE, 15, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_DELETE, 15, 0, 12345));
    queue_cmd(mk_cmd(sse_pkg::MODE_LIST, 15, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_UNION, 14, 15, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_SYMDIFF, 14, 14, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_UNION, 15, 15, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_INTER, 15, 15, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_DIFF, 15, 6, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_LIST, 15, 0, 0));
    drain_all();

    // Fill two sets to capacity, then overflow them.
    for (int k = 0; k < 33; k++) queue_cmd(mk_cmd(sse_pkg::MODE_INSERT, 0, 0, 2 * k - 40));
    for (int k = 0; k < 32; k++) queue_cmd(mk_cmd(sse_pkg::MODE_INSERT, 1, 0, 2 * k - 39));
    queue_cmd(mk_cmd(sse_pkg::MODE_LIST, 0, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_UNION, 2, 0, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_SYMDIFF, 0, 1, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_UNION, 1, 2, 0));
    queue_cmd(mk_cmd(sse_pkg::MODE_LIST, 1, 0, 0));
    drain_all();

    // Random phases with varied idling on each side.
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 24 : (ph == 1) ? 86 : 0;
      out_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 24 : 0;
      for (int k = 0; k < 56; k++) begin
        queue_cmd(rand_cmd());
        if (k == 28) begin
          // hold off the sender until everything outstanding has come back
          while (cmd_queue.size() > 0 || in_valid_i) @(posedge clk_i);
          hold_in = 1'b1;
          while (expected_results.size() > 0) @(posedge clk_i);
          hold_in = 1'b0;
        end
      end
      drain_all();
    end
    repeat (400) @(posedge clk_i);

    $display("covered %0d commands, %0d results, %0d lists, %0d overflows",
             cmds_sent, results_seen, lists_seen, ovf_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results never came", mismatches,
               expected_results.size());
      $display("simulation failed");
    end
    $finish;
  end

  // Give up on a hang; far above the slowest legal run.
  initial begin
    #20ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/sse_pkg.sv
src/sse_ctrl.sv
src/sse_dp.sv
src/sorted_set_bank_engine.sv
dv/tb_top.sv
